FILE: src/io_address_window_table_assert.svh
// ----------------------------------------------------------------------------
// I/O address window table: assertion macros
// Concurrent assertion helpers shared by the table's modules. They are
// clocked on aclk and held off while aresetn is low; synthesis sees them empty.
// ----------------------------------------------------------------------------
`ifndef IO_ADDRESS_WINDOW_TABLE_ASSERT_SVH
`define IO_ADDRESS_WINDOW_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold in the same cycle as its condition.
`define IOAWT_ASSERT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// A property that must hold in the cycle after its condition.
`define IOAWT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`else

`define IOAWT_ASSERT(label, pre, post, msg)
`define IOAWT_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

FILE: src/ioawt_pkg.sv
// ----------------------------------------------------------------------------
// I/O address window table: shared package
// Field widths, operation and status codes, the table entry layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ioawt_pkg;

    // Field widths of the transfers.
    localparam int ADDR_W   = 64;
    localparam int LEN_W    = 32;
    localparam int MODE_W   = 2;
    localparam int DEV_W    = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    // Address sums are kept one bit wider so that nothing wraps.
    localparam int SUM_W    = ADDR_W + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_READ     = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE    = 2'd2;

    // Permission bits within a window's mode.
    localparam int MODE_READ_BIT  = 0;
    localparam int MODE_WRITE_BIT = 1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OVERLAP       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL          = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_RANGE      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_PERMITTED = 3'd4;

    // One stored window.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
        logic [MODE_W-1:0] mode;
        logic [DEV_W-1:0]  device;
    } window_entry_t;

    // Controller states.
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_SCAN,
        CTL_DRAIN,
        CTL_FINISH
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted item and clear the scan flags
        logic issue;       // read the table entry at the scan index
        logic issue_last;  // the entry being read is the last one
        logic emit;        // load the result register and update the table
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // the last entry has passed the compare stage
        logic out_free;    // the result register can take a result this cycle
    } dp_status_t;

endpackage

FILE: src/io_address_window_table.sv
// ----------------------------------------------------------------------------
// I/O address window table
// Registers memory-mapped I/O windows and decodes read and write accesses
// against them, returning the serving device and the offset into its window.
// ----------------------------------------------------------------------------
// Each item is worked against the table one entry per cycle through its single
// read port: the controller accepts it, reads every entry, waits for the read
// and compare stages to drain and then loads the result register once that is
// free. A finished result waits in the output register while the next item is
// already accepted.
// There is no clearing pass: the valid bits are cleared by reset at once.

module io_address_window_table #(
    parameter int WINDOWS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ioawt_pkg::OP_W-1:0]     s_operation,
    input  logic [ioawt_pkg::ADDR_W-1:0]   s_address,
    input  logic [ioawt_pkg::LEN_W-1:0]    s_length,
    input  logic [ioawt_pkg::MODE_W-1:0]   s_mode,
    input  logic [ioawt_pkg::DEV_W-1:0]    s_device_id,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ioawt_pkg::STATUS_W-1:0] m_status,
    output logic [ioawt_pkg::DEV_W-1:0]    m_hit_device,
    output logic [ioawt_pkg::ADDR_W-1:0]   m_offset
);

    localparam int IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;

    ioawt_pkg::ctl_cmd_t   cmd;
    ioawt_pkg::dp_status_t status;
    logic [IDX_W-1:0]      scan_idx;

    // Sequencer.
    ioawt_controller #(
        .WINDOWS (WINDOWS),
        .IDX_W   (IDX_W)
    ) u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd),
        .scan_idx (scan_idx)
    );

    // Table, compare pipeline and result register.
    ioawt_datapath #(
        .WINDOWS (WINDOWS),
        .IDX_W   (IDX_W)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .scan_idx     (scan_idx),
        .status       (status),
        .s_operation  (s_operation),
        .s_address    (s_address),
        .s_length     (s_length),
        .s_mode       (s_mode),
        .s_device_id  (s_device_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_hit_device (m_hit_device),
        .m_offset     (m_offset)
    );

endmodule

FILE: src/ioawt_controller.sv
// ----------------------------------------------------------------------------
// I/O address window table: controller
// Accepts an item, steps the scan index over every table entry, waits for
// the compare pipeline to drain and then hands the result to the output.
// ----------------------------------------------------------------------------
`include "io_address_window_table_assert.svh"

module ioawt_controller #(
    parameter int WINDOWS = 16,
    parameter int IDX_W   = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ioawt_pkg::dp_status_t status,
    output ioawt_pkg::ctl_cmd_t   cmd,
    output logic [IDX_W-1:0]      scan_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOWS - 1);

    ioawt_pkg::ctl_state_t state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;

    // State and scan index registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ioawt_pkg::CTL_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        case (state_reg)
            ioawt_pkg::CTL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ioawt_pkg::CTL_SCAN;
                end
            end
            ioawt_pkg::CTL_SCAN: begin
                cmd.issue = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    cmd.issue_last = 1'b1;
                    state_next     = ioawt_pkg::CTL_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ioawt_pkg::CTL_DRAIN: begin
                if (status.scan_done) begin
                    state_next = ioawt_pkg::CTL_FINISH;
                end
            end
            ioawt_pkg::CTL_FINISH: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ioawt_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = ioawt_pkg::CTL_IDLE;
            end
        endcase
    end

    assign scan_idx = idx_reg;

    // An accepted item always starts its scan at the first slot.
    `IOAWT_ASSERT_NEXT(a_scan_starts_at_zero, s_valid && s_ready, state_reg == ioawt_pkg::CTL_SCAN && idx_reg == '0, "scan did not start at slot zero")
    // The done flag of the previous item must be cleared before a scan runs.
    `IOAWT_ASSERT(a_no_stale_done, state_reg == ioawt_pkg::CTL_SCAN, !status.scan_done, "stale scan done during scan")

endmodule

FILE: src/ioawt_datapath.sv
// ----------------------------------------------------------------------------
// I/O address window table: datapath
// Holds the window table, the item under work, a two-stage compare pipeline
// behind the table read port, the scan flags and the result register.
// ----------------------------------------------------------------------------
`include "io_address_window_table_assert.svh"

module ioawt_datapath #(
    parameter int WINDOWS = 16,
    parameter int IDX_W   = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ioawt_pkg::ctl_cmd_t                 cmd,
    input  logic [IDX_W-1:0]                    scan_idx,
    output ioawt_pkg::dp_status_t               status,
    input  logic [ioawt_pkg::OP_W-1:0]          s_operation,
    input  logic [ioawt_pkg::ADDR_W-1:0]        s_address,
    input  logic [ioawt_pkg::LEN_W-1:0]         s_length,
    input  logic [ioawt_pkg::MODE_W-1:0]        s_mode,
    input  logic [ioawt_pkg::DEV_W-1:0]         s_device_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ioawt_pkg::STATUS_W-1:0]      m_status,
    output logic [ioawt_pkg::DEV_W-1:0]         m_hit_device,
    output logic [ioawt_pkg::ADDR_W-1:0]        m_offset
);

    // Item under work.
    logic [ioawt_pkg::OP_W-1:0]    op_reg;
    logic [ioawt_pkg::ADDR_W-1:0]  addr_reg;
    logic [ioawt_pkg::LEN_W-1:0]   len_reg;
    logic [ioawt_pkg::MODE_W-1:0]  mode_reg;
    logic [ioawt_pkg::DEV_W-1:0]   dev_reg;
    logic [ioawt_pkg::SUM_W-1:0]   item_end_reg;

    // Window table and its valid bits.
    ioawt_pkg::window_entry_t      table_mem [WINDOWS];
    logic [WINDOWS-1:0]            valid_reg;

    // Read stage.
    ioawt_pkg::window_entry_t      rd_entry_reg;
    logic                          rd_win_valid_reg;
    logic [IDX_W-1:0]              rd_idx_reg;
    logic                          rd_live_reg;
    logic                          rd_last_reg;

    // Compare stage.
    logic [ioawt_pkg::ADDR_W-1:0]  e_base_reg;
    logic [ioawt_pkg::SUM_W-1:0]   e_end_reg;
    logic [ioawt_pkg::MODE_W-1:0]  e_mode_reg;
    logic [ioawt_pkg::DEV_W-1:0]   e_dev_reg;
    logic                          e_win_valid_reg;
    logic [IDX_W-1:0]              e_idx_reg;
    logic                          e_live_reg;
    logic                          e_last_reg;

    // Scan flags.
    logic                          clash_reg;
    logic                          free_found_reg;
    logic [IDX_W-1:0]              free_idx_reg;
    logic                          hit_found_reg;
    logic [ioawt_pkg::ADDR_W-1:0]  hit_base_reg;
    logic [ioawt_pkg::MODE_W-1:0]  hit_mode_reg;
    logic [ioawt_pkg::DEV_W-1:0]   hit_dev_reg;
    logic                          done_reg;

    // Result register.
    logic                          m_valid_reg;
    logic [ioawt_pkg::STATUS_W-1:0] m_status_reg;
    logic [ioawt_pkg::DEV_W-1:0]   m_hit_device_reg;
    logic [ioawt_pkg::ADDR_W-1:0]  m_offset_reg;

    logic                          is_register;
    logic [ioawt_pkg::SUM_W-1:0]   cmp1_lhs, cmp1_rhs, cmp2_lhs, cmp2_rhs;
    logic                          lt1, lt2;
    logic                          overlap, contained;
    logic [ioawt_pkg::STATUS_W-1:0] res_status;
    logic [ioawt_pkg::DEV_W-1:0]   res_device;
    logic [ioawt_pkg::ADDR_W-1:0]  res_offset;
    logic                          permitted;
    logic                          table_write;

    assign is_register = (op_reg == ioawt_pkg::OP_REGISTER);

    // Capture the accepted item together with its exact end address.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_operation;
            addr_reg     <= s_address;
            len_reg      <= s_length;
            mode_reg     <= s_mode;
            dev_reg      <= s_device_id;
            item_end_reg <= {1'b0, s_address} + {{(ioawt_pkg::SUM_W - ioawt_pkg::LEN_W){1'b0}},
                                                 s_length};
        end
    end

    // Table write port and registered read port.
    always_ff @(posedge aclk) begin
        if (table_write) begin
            table_mem[free_idx_reg] <= '{base:   addr_reg,
                                         length: len_reg,
                                         mode:   mode_reg,
                                         device: dev_reg};
        end
        if (cmd.issue) begin
            rd_entry_reg <= table_mem[scan_idx];
        end
    end

    // Valid bits; a slot becomes valid when a window is registered into it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (table_write) begin
            valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // Read stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_live_reg <= 1'b0;
            rd_last_reg <= 1'b0;
        end else begin
            rd_live_reg <= cmd.issue;
            rd_last_reg <= cmd.issue_last;
        end
        if (cmd.issue) begin
            rd_win_valid_reg <= valid_reg[scan_idx];
            rd_idx_reg       <= scan_idx;
        end
    end

    // First compare stage: the exact end address of the window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_live_reg <= 1'b0;
            e_last_reg <= 1'b0;
        end else begin
            e_live_reg <= rd_live_reg;
            e_last_reg <= rd_last_reg;
        end
        e_base_reg      <= rd_entry_reg.base;
        e_end_reg       <= {1'b0, rd_entry_reg.base}
                         + {{(ioawt_pkg::SUM_W - ioawt_pkg::LEN_W){1'b0}}, rd_entry_reg.length};
        e_mode_reg      <= rd_entry_reg.mode;
        e_dev_reg       <= rd_entry_reg.device;
        e_win_valid_reg <= rd_win_valid_reg;
        e_idx_reg       <= rd_idx_reg;
    end

    // Second compare stage: two comparators shared between the overlap test of
    // a registration and the containment test of an access.
    always_comb begin
        cmp1_lhs = {1'b0, addr_reg};
        cmp2_rhs = item_end_reg;
        if (is_register) begin
            cmp1_rhs = e_end_reg;
            cmp2_lhs = {1'b0, e_base_reg};
        end else begin
            cmp1_rhs = {1'b0, e_base_reg};
            cmp2_lhs = e_end_reg;
        end
        lt1       = (cmp1_lhs < cmp1_rhs);
        lt2       = (cmp2_lhs < cmp2_rhs);
        overlap   = e_win_valid_reg && lt1 && lt2;
        contained = e_win_valid_reg && !lt1 && !lt2;
    end

    // Scan flags; the lowest free slot and the lowest matching window win.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clash_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end else if (cmd.load) begin
            clash_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end else if (e_live_reg) begin
            if (is_register && overlap) begin
                clash_reg <= 1'b1;
            end
            if (!e_win_valid_reg && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
            if (!is_register && contained && !hit_found_reg) begin
                hit_found_reg <= 1'b1;
            end
            done_reg <= e_last_reg;
        end
    end

    // Payload of the scan flags.
    always_ff @(posedge aclk) begin
        if (e_live_reg) begin
            if (!e_win_valid_reg && !free_found_reg) begin
                free_idx_reg <= e_idx_reg;
            end
            if (contained && !hit_found_reg) begin
                hit_base_reg <= e_base_reg;
                hit_mode_reg <= e_mode_reg;
                hit_dev_reg  <= e_dev_reg;
            end
        end
    end

    // Result of the finished scan.
    always_comb begin
        res_status = ioawt_pkg::ST_NO_RANGE;
        res_device = '0;
        res_offset = '0;
        permitted  = 1'b0;
        case (op_reg)
            ioawt_pkg::OP_REGISTER: begin
                if (clash_reg) begin
                    res_status = ioawt_pkg::ST_OVERLAP;
                end else if (!free_found_reg) begin
                    res_status = ioawt_pkg::ST_FULL;
                end else begin
                    res_status = ioawt_pkg::ST_OK;
                end
            end
            ioawt_pkg::OP_READ, ioawt_pkg::OP_WRITE: begin
                if (op_reg == ioawt_pkg::OP_READ) begin
                    permitted = hit_mode_reg[ioawt_pkg::MODE_READ_BIT];
                end else begin
                    permitted = hit_mode_reg[ioawt_pkg::MODE_WRITE_BIT];
                end
                if (!hit_found_reg) begin
                    res_status = ioawt_pkg::ST_NO_RANGE;
                end else if (!permitted) begin
                    res_status = ioawt_pkg::ST_NOT_PERMITTED;
                end else begin
                    res_status = ioawt_pkg::ST_OK;
                    res_device = hit_dev_reg;
                    res_offset = addr_reg - hit_base_reg;
                end
            end
            default: begin
                res_status = ioawt_pkg::ST_NO_RANGE;
            end
        endcase
    end

    assign table_write = cmd.emit && is_register && (res_status == ioawt_pkg::ST_OK);

    // Result register; it frees itself when the transfer is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            m_status_reg     <= res_status;
            m_hit_device_reg <= res_device;
            m_offset_reg     <= res_offset;
        end
    end

    assign status.scan_done = done_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_hit_device = m_hit_device_reg;
    assign m_offset     = m_offset_reg;

    // A successful registration claims exactly one new slot.
    `IOAWT_ASSERT_NEXT(a_register_claims_slot, table_write, $countones(valid_reg) == $countones($past(valid_reg)) + 1, "registration did not claim one slot")
    // Only a successful access carries a device and an offset.
    `IOAWT_ASSERT(a_fields_zero_unless_ok, m_valid_reg && m_status_reg != ioawt_pkg::ST_OK, m_hit_device_reg == '0 && m_offset_reg == '0, "result fields set on a failed transfer")

endmodule

FILE: tb/sv/io_address_window_table_tb.sv
// ----------------------------------------------------------------------------
// I/O address window table: self-checking testbench
// A short table of directed requests is followed by random window
// registrations and accesses. Every result transfer is checked field by field
// against a behavioural decoder held in the bench, or against the value typed
// into the table where it is obvious. Both channels idle at random, the
// receiver holds off for a long stretch once, and the sender drains once part
// way through and again at the end.
module io_address_window_table_tb;

    import ioawt_pkg::*;

    localparam int WINDOWS        = 16;
    localparam int RANDOM_COUNT   = 400;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int TAIL_CYCLES    = 60;
    localparam int RX_HOLD_AT     = 120;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_AT       = 200;

    // Operation code outside the defined set.
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    // Window permission codes.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RW   = 2'd3;

    // Where the expected result of a request comes from.
    localparam logic FROM_MODEL = 1'b0;
    localparam logic FROM_TABLE = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [MODE_W-1:0] mode;
        logic [DEV_W-1:0]  dev;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DEV_W-1:0]    dev;
        logic [ADDR_W-1:0]   offset;
    } result_t;

    typedef struct packed {
        request_t req;
        logic     source;
        result_t  res;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 23;

    // Directed requests, walked in order from an empty table.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Accesses and an unknown operation against the empty table.
        '{'{OP_READ, 64'h0, 32'd1, MODE_NONE, 8'h00},
          FROM_TABLE, '{ST_NO_RANGE, 8'h00, 64'h0}},
        '{'{OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, MODE_NONE, 8'h00},
          FROM_TABLE, '{ST_NO_RANGE, 8'h00, 64'h0}},
        '{'{OP_UNKNOWN, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, MODE_RW, 8'hFF},
          FROM_TABLE, '{ST_NO_RANGE, 8'h00, 64'h0}},
        // First window at the bottom of the address space, then a clash.
        '{'{OP_REGISTER, 64'h0, 32'h1000, MODE_RW, 8'h11},
          FROM_TABLE, '{ST_OK, 8'h00, 64'h0}},
        '{'{OP_REGISTER, 64'h800, 32'h10, MODE_RW, 8'h12},
          FROM_TABLE, '{ST_OVERLAP, 8'h00, 64'h0}},
        // A read-only window running past the top of the address space.
        '{'{OP_REGISTER, 64'hFFFF_FFFF_FFFF_F000, 32'hFFFF_FFFF, MODE_RD, 8'hFF},
          FROM_TABLE, '{ST_OK, 8'h00, 64'h0}},
        '{'{OP_READ, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, MODE_NONE, 8'h00},
          FROM_TABLE, '{ST_OK, 8'hFF, 64'hFFF}},
        '{'{OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, MODE_NONE, 8'h00},
          FROM_TABLE, '{ST_NOT_PERMITTED, 8'h00, 64'h0}},
        // A zero-length window, and a window touching both neighbours.
        '{'{OP_REGISTER, 64'h2000, 32'd0, MODE_WR, 8'h22},
          FROM_MODEL, '0},
        '{'{OP_REGISTER, 64'h1000, 32'h1000, MODE_WR, 8'h33},
          FROM_MODEL, '0},
        // Zero-length accesses matching several windows: the lowest wins.
        '{'{OP_WRITE, 64'h2000, 32'd0, MODE_NONE, 8'h00},
          FROM_MODEL, '0},
        '{'{OP_READ, 64'h1000, 32'd0, MODE_NONE, 8'h00},
          FROM_MODEL, '0},
        // An access straddling two windows.
        '{'{OP_READ, 64'hFFF, 32'd2, MODE_NONE, 8'h00},
          FROM_MODEL, '0},
        // A window with no permission at all.
        '{'{OP_REGISTER, 64'h10000, 32'h100, MODE_NONE, 8'h44},
          FROM_MODEL, '0},
        '{'{OP_READ, 64'h10000, 32'd1, MODE_NONE, 8'h00},
          FROM_TABLE, '{ST_NOT_PERMITTED, 8'h00, 64'h0}},
        '{'{OP_READ, 64'h0, 32'h1000, MODE_NONE, 8'h00},
          FROM_TABLE, '{ST_OK, 8'h11, 64'h0}},
        '{'{OP_READ, 64'h0, 32'hFFFF_FFFF, MODE_NONE, 8'h00},
          FROM_MODEL, '0},
        // A window based on the zero-length one, and one strictly inside.
        '{'{OP_REGISTER, 64'h2000, 32'h10, MODE_RW, 8'h55},
          FROM_MODEL, '0},
        '{'{OP_REGISTER, 64'h1800, 32'd0, MODE_RW, 8'h66},
          FROM_MODEL, '0},
        '{'{OP_WRITE, 64'h20, 32'd4, MODE_RW, 8'hAA},
          FROM_MODEL, '0},
        '{'{OP_READ, 64'h1000, 32'h1000, MODE_NONE, 8'h00},
          FROM_MODEL, '0},
        '{'{OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, MODE_RW, 8'h77},
          FROM_MODEL, '0},
        '{'{OP_WRITE, 64'h2010, 32'd0, MODE_NONE, 8'h00},
          FROM_MODEL, '0}
    };

    // Clock, reset and the ports of the block.
    logic                aclk         = 1'b0;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation  = '0;
    logic [ADDR_W-1:0]   s_address    = '0;
    logic [LEN_W-1:0]    s_length     = '0;
    logic [MODE_W-1:0]   s_mode       = '0;
    logic [DEV_W-1:0]    s_device_id  = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [DEV_W-1:0]    m_hit_device;
    logic [ADDR_W-1:0]   m_offset;

    // Expected result travelling with the request on offer.
    logic    offer_source = FROM_MODEL;
    result_t offer_result = '0;

    // Idling percentages of the two channels.
    int tx_idle_pct = 15;
    int rx_idle_pct = 51;

    // Decoder state: the window table as the bench sees it.
    logic              win_used   [WINDOWS];
    logic [ADDR_W-1:0] win_base   [WINDOWS];
    logic [LEN_W-1:0]  win_length [WINDOWS];
    logic [MODE_W-1:0] win_mode   [WINDOWS];
    logic [DEV_W-1:0]  win_device [WINDOWS];

    result_t pending_results [$];
    result_t predicted;
    result_t oldest;
    int      error_count    = 0;
    int      accepted_count = 0;
    int      checked_count  = 0;
    int      status_seen [5];
    int      cycle_count    = 0;
    int      rx_transfers   = 0;
    int      rx_hold_left   = 0;
    logic    rx_hold_done   = 1'b0;

    io_address_window_table #(
        .WINDOWS (WINDOWS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_address    (s_address),
        .s_length     (s_length),
        .s_mode       (s_mode),
        .s_device_id  (s_device_id),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_hit_device (m_hit_device),
        .m_offset     (m_offset)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int i = 0; i < WINDOWS; i++) begin
            win_used[i] = 1'b0;
        end
        for (int i = 0; i < 5; i++) begin
            status_seen[i] = 0;
        end
    end

    // Decodes one request against the bench's table, updating it on a
    // successful registration. Sums are taken one bit wider so none wraps.
    function automatic result_t decode_request(input request_t req);
        result_t          res;
        int               free_slot;
        int               hit;
        logic             clash;
        logic [SUM_W-1:0] req_end;
        logic [SUM_W-1:0] win_end;
        res       = '{ST_NO_RANGE, 8'h00, 64'h0};
        free_slot = -1;
        hit       = -1;
        clash     = 1'b0;
        req_end   = {1'b0, req.addr} + req.len;
        if (req.op == OP_REGISTER) begin
            for (int i = 0; i < WINDOWS; i++) begin
                win_end = {1'b0, win_base[i]} + win_length[i];
                if (win_used[i]) begin
                    if ({1'b0, req.addr} < win_end && {1'b0, win_base[i]} < req_end)
                        clash = 1'b1;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (clash) begin
                res.status = ST_OVERLAP;
            end else if (free_slot < 0) begin
                res.status = ST_FULL;
            end else begin
                win_used[free_slot]   = 1'b1;
                win_base[free_slot]   = req.addr;
                win_length[free_slot] = req.len;
                win_mode[free_slot]   = req.mode;
                win_device[free_slot] = req.dev;
                res.status            = ST_OK;
            end
        end else if (req.op == OP_READ || req.op == OP_WRITE) begin
            for (int i = 0; i < WINDOWS; i++) begin
                win_end = {1'b0, win_base[i]} + win_length[i];
                if (hit < 0 && win_used[i] && req.addr >= win_base[i] && req_end <= win_end)
                    hit = i;
            end
            if (hit < 0) begin
                res.status = ST_NO_RANGE;
            end else if ((req.op == OP_READ && !win_mode[hit][MODE_READ_BIT]) ||
                         (req.op == OP_WRITE && !win_mode[hit][MODE_WRITE_BIT])) begin
                res.status = ST_NOT_PERMITTED;
            end else begin
                res.status = ST_OK;
                res.dev    = win_device[hit];
                res.offset = req.addr - win_base[hit];
            end
        end
        return res;
    endfunction

    // Builds a random request. Most are accesses aimed at held windows, at
    // their edges or just past them; some register windows; a few are noise.
    function automatic request_t random_request();
        request_t          req;
        int                used_slots [$];
        int                pick;
        int                kind;
        logic [LEN_W-1:0]  wlen;
        logic [LEN_W-1:0]  off;
        logic [ADDR_W-1:0] base;
        for (int i = 0; i < WINDOWS; i++) begin
            if (win_used[i])
                used_slots.push_back(i);
        end
        req.addr = {$urandom, $urandom};
        req.len  = $urandom;
        req.mode = MODE_W'($urandom_range(3));
        req.dev  = DEV_W'($urandom_range(255));
        pick     = $urandom_range(99);
        if (used_slots.size() > 0) begin
            kind = used_slots[$urandom_range(used_slots.size() - 1)];
            base = win_base[kind];
            wlen = win_length[kind];
        end else begin
            base = req.addr;
            wlen = 32'd0;
        end
        if (pick < 12) begin
            // Window registration: random, abutting a held window, or at the top.
            req.op = OP_REGISTER;
            case ($urandom_range(3))
                0: req.addr = base + wlen - $urandom_range(4);
                1: req.addr = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(4096);
                default: ;
            endcase
            case ($urandom_range(9))
                0:       req.len = 32'd0;
                1, 2, 3: req.len = $urandom_range(256, 1);
                4, 5:    req.len = $urandom_range(65536, 1);
                default: ;
            endcase
        end else if (pick < 17) begin
            // Noise, the unknown operation included.
            req.op = OP_W'($urandom_range(3));
        end else begin
            req.op = $urandom_range(1) ? OP_WRITE : OP_READ;
            kind   = $urandom_range(9);
            if (kind <= 5) begin
                // Wholly inside the window.
                off      = $urandom_range(wlen);
                req.addr = base + off;
                req.len  = $urandom_range(wlen - off);
            end else if (kind == 6) begin
                // Running over the end of the window.
                off      = (wlen > 16) ? wlen - $urandom_range(16, 1) : 32'd0;
                req.addr = base + off;
                req.len  = wlen - off + $urandom_range(16, 1);
            end else if (kind == 7) begin
                // Starting just below the base.
                req.addr = base - $urandom_range(64, 1);
                req.len  = $urandom_range(128, 1);
            end else if (kind == 8) begin
                // Zero length at the window end.
                req.addr = base + wlen;
                req.len  = 32'd0;
            end
        end
        return req;
    endfunction

    // Offers one request after a random idle stretch and waits for its transfer.
    task automatic send_request(input request_t req, input logic source,
                                input result_t res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= req.op;
        s_address    <= req.addr;
        s_length     <= req.len;
        s_mode       <= req.mode;
        s_device_id  <= req.dev;
        offer_source <= source;
        offer_result <= res;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Takes the sender off the channel and waits until every result is in.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Predicts each accepted request and checks each result transfer
    // against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = decode_request('{s_operation, s_address, s_length,
                                             s_mode, s_device_id});
                if (offer_source == FROM_TABLE)
                    predicted = offer_result;
                pending_results.push_back(predicted);
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d", m_status);
                    error_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    checked_count++;
                    if (oldest.status < 5)
                        status_seen[oldest.status]++;
                    if (m_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_status);
                        error_count++;
                    end
                    if (m_hit_device !== oldest.dev) begin
                        $error("hit_device: expected %0h, actual %0h",
                               oldest.dev, m_hit_device);
                        error_count++;
                    end
                    if (m_offset !== oldest.offset) begin
                        $error("offset: expected %0h, actual %0h", oldest.offset, m_offset);
                        error_count++;
                    end
                end
            end
        end
    end

    // Receiver: random back-pressure, with one long hold-off part way through.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                rx_transfers++;
            if (rx_transfers == RX_HOLD_AT && !rx_hold_done) begin
                rx_hold_done = 1'b1;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("io_address_window_table_tb: done, errors");
            $finish;
        end
    end

    // Stimulus: reset, the directed table, then the random phases.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int n = 0; n < DIRECTED_COUNT; n++) begin
            send_request(DIRECTED_ROWS[n].req, DIRECTED_ROWS[n].source,
                         DIRECTED_ROWS[n].res);
        end

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            // Swap the idling of the two sides, then stop idling altogether.
            if (n == RANDOM_COUNT / 3) begin
                tx_idle_pct <= 51;
                rx_idle_pct <= 15;
            end else if (n == 2 * RANDOM_COUNT / 3) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
            end
            if (n == DRAIN_AT)
                drain_results();
            send_request(random_request(), FROM_MODEL, '0);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d requests sent, %0d results checked after a long receiver hold-off",
                 accepted_count, checked_count);
        $display("statuses: ok %0d, overlap %0d, full %0d, no range %0d, not permitted %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("io_address_window_table_tb: done, clean");
        end else begin
            $display("io_address_window_table_tb: done, errors");
        end
        $finish;
    end

endmodule
